FILE: rtl/core/ils_pkg.sv
// shared types and constants for the indexed list store
package ils_pkg;

	// operation codes
	localparam logic [2:0] OP_GET  = 3'd0;
	localparam logic [2:0] OP_HEAD = 3'd1;
	localparam logic [2:0] OP_TAIL = 3'd2;
	localparam logic [2:0] OP_AT   = 3'd3;
	localparam logic [2:0] OP_DEL  = 3'd4;

	// status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned OP_W   = 3;
	localparam int unsigned POS_W  = 8;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned LEN_W  = 9;

	// cells per read group
	localparam int unsigned GROUP = 16;

	typedef logic signed [DATA_W-1:0] word_t;

	// per-cycle shift command to the row of cells
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

FILE: rtl/core/ils_req_if.sv
// request channel: operation, position and value
interface ils_req_if;
	import ils_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [POS_W-1:0]    position;
	word_t               value;

	modport source (output valid, operation, position, value, input ready);
	modport sink   (input valid, operation, position, value, output ready);
endinterface

FILE: rtl/core/ils_rsp_if.sv
// response channel: read value, status and length
interface ils_rsp_if;
	import ils_pkg::*;

	logic                valid;
	logic                ready;
	word_t               read_value;
	logic [STAT_W-1:0]   status;
	logic [LEN_W-1:0]    length;

	modport source (output valid, read_value, status, length, input ready);
	modport sink   (input valid, read_value, status, length, output ready);
endinterface

FILE: rtl/core/ils_cell.sv
// one list cell: holds one entry, shifts with its neighbors
module ils_cell #(
	parameter int unsigned SEL_W = 9,
	parameter int unsigned INDEX = 0
) (
	input  logic                clk,
	input  ils_pkg::cell_ctl_t  ctl,
	input  logic [SEL_W-1:0]    sel,
	input  ils_pkg::word_t      ins_value,
	input  ils_pkg::word_t      left,
	input  ils_pkg::word_t      right,
	output ils_pkg::word_t      entry,
	output ils_pkg::word_t      rd
);
	import ils_pkg::*;

	localparam logic [SEL_W-1:0] IDX = SEL_W'(INDEX);

	word_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (IDX > sel) begin
				entry_q <= left;
			end else if (IDX == sel) begin
				entry_q <= ins_value;
			end
		end else if (ctl.del && (IDX >= sel)) begin
			entry_q <= right;
		end
	end

	assign entry = entry_q;
	// only the addressed cell drives its read lane
	assign rd = (IDX == sel) ? entry_q : '0;

endmodule

FILE: rtl/core/ils_chain.sv
// row of cells with a registered two-level read tree
module ils_chain #(
	parameter int unsigned CAPACITY = 256,
	parameter int unsigned SEL_W    = 9
) (
	input  logic                clk,
	input  ils_pkg::cell_ctl_t  ctl,
	input  logic [SEL_W-1:0]    sel,
	input  ils_pkg::word_t      ins_value,
	input  logic                load,
	output ils_pkg::word_t      rd_word
);
	import ils_pkg::*;

	localparam int unsigned NG = (CAPACITY + GROUP - 1) / GROUP;

	word_t entry_w [CAPACITY];
	word_t rd_w    [CAPACITY];
	word_t grp_d   [NG];
	word_t grp_s1  [NG];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t left_w;
		word_t right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = entry_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = entry_w[i+1];
		end
		ils_cell #(
			.SEL_W (SEL_W),
			.INDEX (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.sel       (sel),
			.ins_value (ins_value),
			.left      (left_w),
			.right     (right_w),
			.entry     (entry_w[i]),
			.rd        (rd_w[i])
		);
	end

	// first level: or within each group of cells
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
		end
		for (int i = 0; i < CAPACITY; i++) begin
			grp_d[i / GROUP] = grp_d[i / GROUP] | rd_w[i];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_s1 <= grp_d;
		end
	end

	// second level: or across groups
	always_comb begin
		rd_word = '0;
		for (int g = 0; g < NG; g++) begin
			rd_word = rd_word | grp_s1[g];
		end
	end

endmodule

FILE: rtl/core/indexed_list_store.sv
// top level of the indexed list store: decode, count, output register
//
//  channel | dir | payload                          | accepted when
//  --------+-----+----------------------------------+------------------------
//  req     | in  | operation, position, value       | req.valid && req.ready
//  rsp     | out | read_value, status, length       | rsp.valid && rsp.ready
//
// one item per cycle sustained while rsp keeps taking results; a result passes
// from the read stage (decode and cell shift, then the registered read tree)
// into the output register, and is on rsp once that register holds it.
// every insert or delete shifts the cells from the selected position on in the
// accept cycle, so the next item sees the updated list at once.
// reset clears the count and the valid flags; the cells are not cleared.
// when rsp stalls, one result waits in the output register and one more in
// the read stage, after which req.ready drops.
module indexed_list_store #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	ils_req_if.sink    req,
	ils_rsp_if.source  rsp
);
	import ils_pkg::*;

	// count width holds CAPACITY itself
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	// width for range compares against the 8-bit position
	localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_d;
	logic [XW-1:0]      pos_x;
	logic [XW-1:0]      cnt_x;
	logic               full;
	logic               accept;
	logic               out_load;

	// decode results for the accepted item
	logic               ins_go;
	logic               del_go;
	logic               rd_ok;
	logic [STAT_W-1:0]  status_d;
	logic [CW-1:0]      sel;
	cell_ctl_t          ctl;
	word_t              rd_word;

	// read stage
	logic               v_s1;
	logic               get_s1;
	logic               rd_ok_s1;
	logic [STAT_W-1:0]  status_s1;
	logic [LEN_W-1:0]   length_s1;

	// output register
	logic               out_v_q;
	word_t              read_value_q;
	logic [STAT_W-1:0]  status_q;
	logic [LEN_W-1:0]   length_q;

	assign out_load  = v_s1 && (!out_v_q || rsp.ready);
	assign req.ready = !v_s1 || out_load;
	assign accept    = req.valid && req.ready;

	assign pos_x = XW'(req.position);
	assign cnt_x = XW'(count_q);
	assign full  = (count_q == CAP_C);

	// operation decode, range check before the full check
	always_comb begin
		ins_go   = 1'b0;
		del_go   = 1'b0;
		rd_ok    = 1'b0;
		status_d = ST_DONE;
		sel      = CW'(pos_x);
		unique case (req.operation)
			OP_GET: begin
				if (pos_x < cnt_x) begin
					rd_ok = 1'b1;
				end else begin
					status_d = ST_RANGE;
				end
			end
			OP_HEAD: begin
				sel = '0;
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ins_go = 1'b1;
				end
			end
			OP_TAIL: begin
				sel = count_q;
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ins_go = 1'b1;
				end
			end
			OP_AT: begin
				if (pos_x > cnt_x) begin
					status_d = ST_RANGE;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					ins_go = 1'b1;
				end
			end
			OP_DEL: begin
				if (pos_x < cnt_x) begin
					del_go = 1'b1;
				end else begin
					status_d = ST_RANGE;
				end
			end
			default: begin
				// unknown codes leave the list alone
			end
		endcase
	end

	// cells only move on an accepted item
	assign ctl.ins = accept && ins_go;
	assign ctl.del = accept && del_go;

	always_comb begin
		count_d = count_q;
		if (ins_go) begin
			count_d = count_q + 1'b1;
		end else if (del_go) begin
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	ils_chain #(
		.CAPACITY (CAPACITY),
		.SEL_W    (CW)
	) u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.sel       (sel),
		.ins_value (req.value),
		.load      (accept),
		.rd_word   (rd_word)
	);

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (out_load) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			get_s1    <= (req.operation == OP_GET);
			rd_ok_s1  <= rd_ok;
			status_s1 <= status_d;
			// length is the new count, cut to the field width
			length_s1 <= LEN_W'(count_d);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (!get_s1) begin
				read_value_q <= '0;
			end else if (rd_ok_s1) begin
				read_value_q <= rd_word;
			end else begin
				read_value_q <= '1;
			end
			status_q <= status_s1;
			length_q <= length_s1;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.read_value = read_value_q;
	assign rsp.status     = status_q;
	assign rsp.length     = length_q;

	// count never runs past the row of cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	// an accepted insert that goes ahead grows the list by one
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ins_go |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the count");

	// an accepted delete shrinks the list by one
	a_del_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && del_go |=> count_q == $past(count_q) - 1'b1)
		else $error("delete did not shrink the count");

	// full is only reported when every cell is in use
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (status_d == ST_FULL) |-> full)
		else $error("full status with free cells");

	// a waiting read stage item is not dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !out_load |=> v_s1)
		else $error("read stage item lost");

endmodule

FILE: tb/indexed_list_store_tb.sv
// testbench for indexed_list_store: directed and random requests checked against a list copy
`timescale 1ns / 100ps

module indexed_list_store_tb;
	import ils_pkg::*;

	localparam int unsigned CAPACITY  = 256;
	localparam int          HALF_PER  = 4;
	localparam int          CYC_LIMIT = 400000;
	localparam int          SETTLE    = 16;

	// what one response should carry
	typedef struct {
		word_t             read_value;
		logic [STAT_W-1:0] status;
		logic [LEN_W-1:0]  length;
	} list_result_t;

	// keeps a copy of the list and the responses still owed by the block
	class list_scoreboard;
		word_t        entry_q[$];
		list_result_t due_q[$];
		int           errors;
		int           full_hits;

		// insert before slot at; the range check comes ahead of the full check
		function logic [STAT_W-1:0] place(int unsigned at, word_t val);
			if (at > entry_q.size())
				return ST_RANGE;
			if (entry_q.size() >= CAPACITY) begin
				full_hits++;
				return ST_FULL;
			end
			entry_q.insert(at, val);
			return ST_DONE;
		endfunction

		// apply an accepted request to the copy and queue its response
		function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, word_t val);
			list_result_t r;
			r.read_value = '0;
			r.status     = ST_DONE;
			case (op)
				OP_GET: begin
					if (pos < entry_q.size()) begin
						r.read_value = entry_q[pos];
					end else begin
						r.read_value = -1;
						r.status     = ST_RANGE;
					end
				end
				OP_HEAD: r.status = place(0, val);
				OP_TAIL: r.status = place(entry_q.size(), val);
				OP_AT:   r.status = place(pos, val);
				OP_DEL: begin
					if (pos < entry_q.size())
						entry_q.delete(pos);
					else
						r.status = ST_RANGE;
				end
				default: ;
			endcase
			r.length = LEN_W'(entry_q.size());
			due_q.push_back(r);
		endfunction

		task report(string msg);
			if (errors < 40)
				$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		// compare one accepted response with the oldest one owed
		task check_result(word_t rd, logic [STAT_W-1:0] st, logic [LEN_W-1:0] len);
			list_result_t e;
			if (due_q.size() == 0) begin
				report($sformatf("response with nothing pending (rd %h st %0d len %0d)",
					rd, st, len));
				return;
			end
			e = due_q.pop_front();
			if (rd !== e.read_value)
				report($sformatf("read_value %h, want %h", rd, e.read_value));
			if (st !== e.status)
				report($sformatf("status %0d, want %0d", st, e.status));
			if (len !== e.length)
				report($sformatf("length %0d, want %0d", len, e.length));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   cycles = 0;

	ils_req_if req_ch ();
	ils_rsp_if rsp_ch ();

	list_scoreboard sb;

	indexed_list_store #(
		.CAPACITY (CAPACITY)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	initial clk = 1'b0;
	always #(HALF_PER) clk = ~clk;

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYC_LIMIT) begin
			$display("** indexed_list_store: FAILED **");
			$finish;
		end
	end

	// response side: checked at the falling edge, where everything driven at
	// the rising edge has settled; the handshake then completes at the next rise
	always @(negedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result(rsp_ch.read_value, rsp_ch.status, rsp_ch.length);
	end

	// receiver stall pattern: switches at random among always ready, random drops,
	// long holds and toggling
	int   rx_mode      = 0;
	int   rx_mode_left = 0;
	int   rx_hold_left = 0;
	logic rx_hold_val  = 1'b0;

	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      = $urandom_range(0, 3);
			rx_mode_left = $urandom_range(64, 256);
		end else begin
			rx_mode_left--;
		end
		case (rx_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= ($urandom_range(0, 9) > 2);
			2: begin
				// long holds low, short runs high
				if (rx_hold_left == 0) begin
					rx_hold_val  = ~rx_hold_val;
					rx_hold_left = rx_hold_val ? $urandom_range(1, 8) : $urandom_range(1, 20);
				end else begin
					rx_hold_left--;
				end
				rsp_ch.ready <= rx_hold_val;
			end
			default: rsp_ch.ready <= (rsp_ch.ready !== 1'b1);
		endcase
	end

	// drive one item and hold it until the block takes it
	task send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, word_t val);
		logic taken;
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.position  <= pos;
		req_ch.value     <= val;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = req_ch.ready;
			if (taken)
				sb.note_request(op, pos, val);
			@(posedge clk);
		end
	endtask

	task idle_cycles(int n);
		req_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// stop sending until every owed response has come back
	task drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.due_q.size() != 0)
			@(posedge clk);
	endtask

	// sender bursts: random length, random gaps, some back-to-back bursts
	int burst_left;

	task pace();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0)
				idle_cycles(gap);
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
	endtask

	// one random request; positions mostly land inside the current list so
	// inserts and deletes actually move entries, the rest are random and may be out of range
	task random_item(int ins_w, int del_w);
		int unsigned      len;
		int unsigned      top;
		int unsigned      pick;
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] pos;
		word_t            val;
		len  = sb.entry_q.size();
		top  = (len > 255) ? 255 : len;
		pick = $urandom_range(0, 99);
		pos  = POS_W'($urandom);
		val  = $urandom;
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: val = 32'h8000_0000;
				1: val = 32'h7fff_ffff;
				2: val = 32'hffff_ffff;
				default: val = '0;
			endcase
		end
		if (pick < ins_w) begin
			case ($urandom_range(0, 2))
				0: op = OP_HEAD;
				1: op = OP_TAIL;
				default: begin
					op = OP_AT;
					if ($urandom_range(0, 7) != 0)
						pos = POS_W'($urandom_range(0, top));
				end
			endcase
		end else if (pick < ins_w + del_w) begin
			op = OP_DEL;
			if (len != 0 && $urandom_range(0, 7) != 0)
				pos = POS_W'($urandom_range(0, len - 1));
		end else if (pick < 96) begin
			op = OP_GET;
			if (len != 0 && $urandom_range(0, 5) != 0)
				pos = POS_W'($urandom_range(0, len - 1));
		end else begin
			// unused operation codes
			op = OP_W'($urandom_range(5, 7));
		end
		send_item(op, pos, val);
	endtask

	initial begin
		int n;
		sb             = new();
		burst_left     = 0;
		arst_n         <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.operation <= OP_GET;
		req_ch.position  <= '0;
		req_ch.value     <= '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, range checks, extremes, every operation
		send_item(OP_GET,  8'd0,   32'h1234_5678);   // get from empty list
		send_item(OP_DEL,  8'd0,   '0);              // delete from empty list
		send_item(OP_AT,   8'd1,   32'h1111_1111);   // insert past the end
		send_item(OP_AT,   8'd0,   32'h8000_0000);   // insert at end of empty list
		send_item(OP_TAIL, 8'hff,  32'h7fff_ffff);
		send_item(OP_HEAD, 8'haa,  32'hffff_ffff);   // stored -1, unlike a bad get
		send_item(OP_AT,   8'd3,   '0);              // position equal to length appends
		send_item(OP_AT,   8'd1,   32'h5a5a_5a5a);
		for (int i = 0; i < 5; i++)
			send_item(OP_GET, i[POS_W-1:0], '0);
		send_item(OP_GET,  8'd5,   '0);              // just past the end
		send_item(OP_GET,  8'hff,  '0);
		send_item(3'd5,    8'h55,  32'hdead_beef);   // unused codes change nothing
		send_item(3'd6,    8'h0f,  32'h0000_0001);
		send_item(3'd7,    8'hf0,  32'hffff_fffe);
		send_item(OP_DEL,  8'd4,   '0);              // last entry
		send_item(OP_DEL,  8'd0,   '0);              // first entry
		send_item(OP_DEL,  8'hff,  '0);
		send_item(OP_AT,   8'd200, 32'h0bad_f00d);
		send_item(OP_GET,  8'd1,   '0);

		// mixed traffic around a short list
		for (int i = 0; i < 150; i++) begin
			pace();
			random_item(35, 30);
		end
		drain_results();

		// fill to capacity and keep pushing so the full case is hit repeatedly
		n = 0;
		while ((n < 300 || sb.full_hits < 6) && n < 600) begin
			pace();
			random_item(88, 4);
			n++;
		end
		drain_results();

		// drain back down to empty, with some deletes past the end
		n = 0;
		while ((n < 280 || sb.entry_q.size() != 0) && n < 600) begin
			pace();
			random_item(5, 85);
			n++;
		end

		for (int i = 0; i < 60; i++) begin
			pace();
			random_item(40, 30);
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0 && sb.due_q.size() == 0) begin
			$display("** indexed_list_store: PASSED **");
		end else begin
			$display("** indexed_list_store: FAILED **");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/ils_pkg.sv
rtl/core/ils_req_if.sv
rtl/core/ils_rsp_if.sv
rtl/core/ils_cell.sv
rtl/core/ils_chain.sv
rtl/core/indexed_list_store.sv
tb/indexed_list_store_tb.sv
